[rtl/core/tks_pkg.sv]
// Shared types, constants and lookup functions for the token scanner.
`default_nettype none

package tks_pkg;

    // Sizes of the scanner state and of the token fields.
    localparam int POS_BITS       = 16;
    localparam int KW_CHARS       = 5;
    localparam int KW_BITS        = 8 * KW_CHARS;
    localparam int LEN_BITS       = 16;
    localparam int START_BITS     = 16;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

    typedef logic [5:0] kind_t;

    // Token kinds: plain classes and keywords.
    localparam kind_t K_ID      = 6'd0;
    localparam kind_t K_NUM     = 6'd1;
    localparam kind_t K_REAL    = 6'd2;
    localparam kind_t K_DO      = 6'd3;
    localparam kind_t K_IF      = 6'd4;
    localparam kind_t K_ELSE    = 6'd5;
    localparam kind_t K_WHILE   = 6'd6;
    localparam kind_t K_BREAK   = 6'd7;
    localparam kind_t K_MAIN    = 6'd8;
    localparam kind_t K_BASIC   = 6'd9;
    // Two-character operators.
    localparam kind_t K_INC     = 6'd10;
    localparam kind_t K_DEC     = 6'd11;
    localparam kind_t K_LE      = 6'd12;
    localparam kind_t K_GE      = 6'd13;
    localparam kind_t K_EQ      = 6'd14;
    localparam kind_t K_LAND    = 6'd15;
    localparam kind_t K_LOR     = 6'd16;
    localparam kind_t K_NE      = 6'd17;
    // Single symbols.
    localparam kind_t K_LPAREN  = 6'd18;
    localparam kind_t K_RPAREN  = 6'd19;
    localparam kind_t K_LBRACK  = 6'd20;
    localparam kind_t K_RBRACK  = 6'd21;
    localparam kind_t K_LBRACE  = 6'd22;
    localparam kind_t K_RBRACE  = 6'd23;
    localparam kind_t K_DOT     = 6'd24;
    localparam kind_t K_PLUS    = 6'd25;
    localparam kind_t K_MINUS   = 6'd26;
    localparam kind_t K_STAR    = 6'd27;
    localparam kind_t K_SLASH   = 6'd28;
    localparam kind_t K_PERCENT = 6'd29;
    localparam kind_t K_LT      = 6'd30;
    localparam kind_t K_GT      = 6'd31;
    localparam kind_t K_ASSIGN  = 6'd32;
    localparam kind_t K_SEMI    = 6'd33;
    localparam kind_t K_COMMA   = 6'd34;
    localparam kind_t K_NOT     = 6'd35;
    localparam kind_t K_AND     = 6'd36;
    localparam kind_t K_OR      = 6'd37;
    localparam kind_t K_UNKNOWN = 6'd38;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_INT,
        MODE_REAL,
        MODE_HELD,
        MODE_COMMENT
    } scan_mode_t;

    // One input beat.
    typedef struct packed {
        logic [7:0] char_in;
        logic       text_end;
    } in_item_t;

    // One output beat.
    typedef struct packed {
        kind_t                 token_kind;
        logic [START_BITS-1:0] lexeme_start;
        logic [LEN_BITS-1:0]   lexeme_length;
        logic                  run_last;
        logic                  stream_end;
    } out_item_t;

    // One queue slot: the tokens caused by one byte, one or two of them.
    typedef struct packed {
        logic      two;
        out_item_t first;
        out_item_t second;
    } slot_t;

    // Kind of a lone symbol byte; anything unlisted is unknown.
    function automatic kind_t single_kind(input logic [7:0] c);
        kind_t k;
        case (c)
            "(":     k = K_LPAREN;
            ")":     k = K_RPAREN;
            "[":     k = K_LBRACK;
            "]":     k = K_RBRACK;
            "{":     k = K_LBRACE;
            "}":     k = K_RBRACE;
            ".":     k = K_DOT;
            "+":     k = K_PLUS;
            "-":     k = K_MINUS;
            "*":     k = K_STAR;
            "/":     k = K_SLASH;
            "%":     k = K_PERCENT;
            "<":     k = K_LT;
            ">":     k = K_GT;
            "=":     k = K_ASSIGN;
            ";":     k = K_SEMI;
            ",":     k = K_COMMA;
            "!":     k = K_NOT;
            "&":     k = K_AND;
            "|":     k = K_OR;
            default: k = K_UNKNOWN;
        endcase
        return k;
    endfunction

    // Kind of a two-byte operator; unknown when the bytes form no pair.
    function automatic kind_t pair_kind(input logic [7:0] a, input logic [7:0] b);
        kind_t k;
        k = K_UNKNOWN;
        if (a == "+" && b == "+") k = K_INC;
        else if (a == "-" && b == "-") k = K_DEC;
        else if (a == "<" && b == "=") k = K_LE;
        else if (a == ">" && b == "=") k = K_GE;
        else if (a == "=" && b == "=") k = K_EQ;
        else if (a == "&" && b == "&") k = K_LAND;
        else if (a == "|" && b == "|") k = K_LOR;
        else if (a == "!" && b == "=") k = K_NE;
        return k;
    endfunction

    // Keyword lookup. The buffer holds the first bytes of the identifier,
    // first byte lowest, and zeros past its length.
    function automatic kind_t keyword_kind(input logic [LEN_BITS-1:0] len,
                                           input logic [KW_BITS-1:0] kbuf);
        kind_t k;
        k = K_ID;
        if (len <= LEN_BITS'(KW_CHARS)) begin
            if (len == LEN_BITS'(2) && kbuf == KW_BITS'({"o", "d"}))
                k = K_DO;
            else if (len == LEN_BITS'(2) && kbuf == KW_BITS'({"f", "i"}))
                k = K_IF;
            else if (len == LEN_BITS'(4) && kbuf == KW_BITS'({"e", "s", "l", "e"}))
                k = K_ELSE;
            else if (len == LEN_BITS'(5) && kbuf == KW_BITS'({"e", "l", "i", "h", "w"}))
                k = K_WHILE;
            else if (len == LEN_BITS'(5) && kbuf == KW_BITS'({"k", "a", "e", "r", "b"}))
                k = K_BREAK;
            else if (len == LEN_BITS'(4) && kbuf == KW_BITS'({"n", "i", "a", "m"}))
                k = K_MAIN;
            else if (len == LEN_BITS'(5) && kbuf == KW_BITS'({"t", "a", "o", "l", "f"}))
                k = K_BASIC;
            else if (len == LEN_BITS'(3) && kbuf == KW_BITS'({"t", "n", "i"}))
                k = K_BASIC;
            else if (len == LEN_BITS'(4) && kbuf == KW_BITS'({"r", "a", "h", "c"}))
                k = K_BASIC;
            else if (len == LEN_BITS'(4) && kbuf == KW_BITS'({"d", "i", "o", "v"}))
                k = K_BASIC;
        end
        return k;
    endfunction

endpackage

`default_nettype wire

[rtl/core/tks_front.sv]
// Front end: takes source bytes, runs the scanner state and packs tokens into queue slots.
`default_nettype none

module tks_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             byte_valid,
    output logic                  byte_stall,
    input  wire tks_pkg::in_item_t byte_data,
    input  wire logic             queue_full,
    output logic                  push,
    output tks_pkg::slot_t        push_data
);
    import tks_pkg::*;

    scan_mode_t              mode_reg,  mode_next,  adv_mode;
    logic [POS_BITS-1:0]     pos_reg,   pos_next;
    logic [POS_BITS-1:0]     start_reg, start_next, adv_start;
    logic [LEN_BITS-1:0]     len_reg,   len_next,   adv_len;
    logic [KW_BITS-1:0]      kw_reg,    kw_next,    adv_kw;
    logic [7:0]              held_reg,  held_next,  adv_held;

    logic [7:0]          c;
    logic                last;
    logic                accept;
    logic                c_space, c_alpha, c_digit, c_holdable;
    logic [LEN_BITS-1:0] len_grown;
    kind_t               pair_k;
    logic                restart;
    logic                pair_hit;
    logic                fresh_emit;
    logic                v1, v2, v3;
    out_item_t           t1, t2, t3;
    out_item_t           first_tok, second_tok;
    logic                have_one, have_two;

    // Token that the given pending state stands for.
    function automatic out_item_t pend_token(input scan_mode_t m,
                                             input logic [POS_BITS-1:0] st,
                                             input logic [LEN_BITS-1:0] ln,
                                             input logic [KW_BITS-1:0] kb,
                                             input logic [7:0] hs);
        out_item_t t;
        t.lexeme_start  = START_BITS'(st);
        t.lexeme_length = ln;
        t.run_last      = 1'b0;
        t.stream_end    = 1'b0;
        case (m)
            MODE_IDENT: t.token_kind = keyword_kind(ln, kb);
            MODE_INT:   t.token_kind = K_NUM;
            MODE_REAL:  t.token_kind = K_REAL;
            MODE_HELD:
            begin
                t.token_kind    = single_kind(hs);
                t.lexeme_length = LEN_BITS'(1);
            end
            default:    t.token_kind = K_UNKNOWN;
        endcase
        return t;
    endfunction

    function automatic logic has_pending(input scan_mode_t m);
        return (m == MODE_IDENT) || (m == MODE_INT) || (m == MODE_REAL) || (m == MODE_HELD);
    endfunction

    // Byte classes.
    assign c          = byte_data.char_in;
    assign last       = byte_data.text_end;
    assign c_space    = (c == " ") || (c >= 8'd9 && c <= 8'd13);
    assign c_alpha    = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    assign c_digit    = (c >= "0" && c <= "9");
    assign c_holdable = (c == "/") || (c == "+") || (c == "-") || (c == "<") ||
                        (c == ">") || (c == "=") || (c == "&") || (c == "|") || (c == "!");
    assign len_grown  = (len_reg == LEN_MAX) ? len_reg : len_reg + LEN_BITS'(1);
    assign pair_k     = pair_kind(held_reg, c);

    // The queue must have room for a whole slot before a byte is taken.
    assign byte_stall = queue_full;
    assign accept     = byte_valid && !queue_full;

    // Scanner state after this byte, before the end-of-text reset.
    always_comb
    begin
        adv_mode   = mode_reg;
        adv_start  = start_reg;
        adv_len    = len_reg;
        adv_kw     = kw_reg;
        adv_held   = held_reg;
        restart    = 1'b0;
        pair_hit   = 1'b0;
        case (mode_reg)
            MODE_IDENT:
            begin
                if (c_alpha || c_digit) begin
                    for (int j = 0; j < KW_CHARS; j++) begin
                        if (len_reg == LEN_BITS'(j))
                            adv_kw[8*j +: 8] = c;
                    end
                    adv_len = len_grown;
                end else begin
                    restart = 1'b1;
                end
            end
            MODE_INT:
            begin
                if (c_digit) begin
                    adv_len = len_grown;
                end else if (c == ".") begin
                    adv_mode = MODE_REAL;
                    adv_len  = len_grown;
                end else begin
                    restart = 1'b1;
                end
            end
            MODE_REAL:
            begin
                if (c_digit)
                    adv_len = len_grown;
                else
                    restart = 1'b1;
            end
            MODE_HELD:
            begin
                if (held_reg == "/" && c == "/") begin
                    adv_mode = MODE_COMMENT;
                end else if (pair_k != K_UNKNOWN) begin
                    adv_mode = MODE_IDLE;
                    pair_hit = 1'b1;
                end else begin
                    restart = 1'b1;
                end
            end
            MODE_COMMENT:
            begin
                if (c == "\n")
                    adv_mode = MODE_IDLE;
            end
            default:
            begin
                restart = 1'b1;
            end
        endcase

        // A byte that is scanned fresh opens a new token.
        fresh_emit = 1'b0;
        if (restart) begin
            adv_mode = MODE_IDLE;
            if (!c_space) begin
                adv_start = pos_reg;
                adv_len   = LEN_BITS'(1);
                if (c_alpha) begin
                    adv_mode = MODE_IDENT;
                    adv_kw   = KW_BITS'(c);
                end else if (c_digit) begin
                    adv_mode = MODE_INT;
                end else if (c_holdable) begin
                    adv_mode = MODE_HELD;
                    adv_held = c;
                end else begin
                    fresh_emit = 1'b1;
                end
            end
        end
    end

    // Register values: the end of the text returns everything to reset.
    always_comb
    begin
        if (last) begin
            mode_next  = MODE_IDLE;
            pos_next   = '0;
            start_next = '0;
            len_next   = '0;
            kw_next    = '0;
            held_next  = '0;
        end else begin
            mode_next  = adv_mode;
            pos_next   = pos_reg + POS_BITS'(1);
            start_next = adv_start;
            len_next   = adv_len;
            kw_next    = adv_kw;
            held_next  = adv_held;
        end
    end

    // Tokens of this byte in text order: the closed token or pair, the
    // byte's own symbol, then whatever is still open at the end of the text.
    always_comb
    begin
        v1 = (restart && has_pending(mode_reg)) || pair_hit;
        t1 = pend_token(mode_reg, start_reg, len_reg, kw_reg, held_reg);
        if (pair_hit) begin
            t1.token_kind    = pair_k;
            t1.lexeme_length = LEN_BITS'(2);
        end

        v2               = fresh_emit;
        t2.token_kind    = single_kind(c);
        t2.lexeme_start  = START_BITS'(pos_reg);
        t2.lexeme_length = LEN_BITS'(1);
        t2.run_last      = 1'b0;
        t2.stream_end    = 1'b0;

        v3 = last && has_pending(adv_mode);
        t3 = pend_token(adv_mode, adv_start, adv_len, adv_kw, adv_held);

        have_one   = v1 || v2 || v3;
        have_two   = (v1 && (v2 || v3)) || (v2 && v3);
        first_tok  = v1 ? t1 : (v2 ? t2 : t3);
        second_tok = (v1 && v2) ? t2 : t3;

        first_tok.run_last    = !have_two;
        first_tok.stream_end  = last;
        second_tok.run_last   = 1'b1;
        second_tok.stream_end = last;

        push             = accept && have_one;
        push_data.two    = have_two;
        push_data.first  = first_tok;
        push_data.second = second_tok;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= MODE_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            kw_reg    <= '0;
            held_reg  <= '0;
        end else if (accept) begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            kw_reg    <= kw_next;
            held_reg  <= held_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/tks_queue.sv]
// Short slot queue between the scanner front end and the token output stage.
`default_nettype none

module tks_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire tks_pkg::slot_t push_data,
    output logic                full,
    output logic                head_valid,
    output tks_pkg::slot_t      head_data,
    input  wire logic           pop
);
    import tks_pkg::*;

    slot_t                     slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_BITS-1:0] count_reg,  count_next;

    assign full       = (count_reg == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + QUEUE_PTR_BITS'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + QUEUE_PTR_BITS'(1);
        end
        if (push && !pop)
            count_next = count_reg + QUEUE_CNT_BITS'(1);
        else if (pop && !push)
            count_next = count_reg - QUEUE_CNT_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

[rtl/core/tks_back.sv]
// Back end: unpacks queue slots into single token beats held in an output register.
`default_nettype none

module tks_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           head_valid,
    input  wire tks_pkg::slot_t head_data,
    output logic                pop,
    output logic                token_valid,
    input  wire logic           token_stall,
    output tks_pkg::out_item_t  token_data
);
    import tks_pkg::*;

    logic      valid_reg, valid_next;
    logic      half_reg,  half_next;
    out_item_t data_reg,  data_next;
    logic      load;

    assign token_valid = valid_reg;
    assign token_data  = data_reg;
    assign load        = !valid_reg || !token_stall;

    // Load the next token when the output register is free or being taken.
    // A two-token slot stays at the head until its second token is loaded.
    always_comb
    begin
        valid_next = valid_reg;
        half_next  = half_reg;
        data_next  = data_reg;
        pop        = 1'b0;
        if (load) begin
            if (head_valid) begin
                valid_next = 1'b1;
                data_next  = half_reg ? head_data.second : head_data.first;
                if (head_data.two && !half_reg) begin
                    half_next = 1'b1;
                end else begin
                    half_next = 1'b0;
                    pop       = 1'b1;
                end
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            half_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            half_reg  <= half_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

[rtl/core/c_like_token_scanner_top.sv]
// Top level of the streaming token scanner for C-like source text.
//
// Source text comes in on the byte channel, one byte per beat, with
// text_end set on the final byte. Tokens leave on the token channel, one
// token per beat, with kind, start position and saturating length.
// A byte is taken in every cycle in which the queue is not full: the front end
// scans it and writes the tokens it closes (none, one or two) as one slot of a
// four-slot queue. The output stage hands out one token per cycle while
// token_stall is low, so a byte that closes two tokens needs an output beat
// for each; a steady run of such bytes fills the queue and byte_stall rises.
// A token goes from its queue slot into the output register and is shown on
// token_valid from there.
// While token_stall is high the output token holds and the queue fills;
// bytes keep coming in until the queue is full.
// Reset empties the queue and the output register and puts the scanner at
// position 0 with nothing pending. The final byte of a text does the same to
// the scanner after flushing any open token, so the next byte opens a new text.
`default_nettype none

module c_like_token_scanner_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               byte_valid,
    output logic                    byte_stall,
    input  wire tks_pkg::in_item_t  byte_data,
    output logic                    token_valid,
    input  wire logic               token_stall,
    output tks_pkg::out_item_t      token_data
);
    import tks_pkg::*;

    logic  push;
    slot_t push_data;
    logic  queue_full;
    logic  head_valid;
    slot_t head_data;
    logic  pop;

    tks_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    tks_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop)
    );

    tks_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_data   (head_data),
        .pop         (pop),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_data  (token_data)
    );

endmodule

`default_nettype wire

[rtl/core/tks_checker.sv]
// Port-level checks on the token scanner, bound to its top level.
`default_nettype none

module tks_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              token_valid,
    input  wire logic              token_stall,
    input  wire tks_pkg::out_item_t token_data
);
    import tks_pkg::*;

    // A stalled token beat stays offered.
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_stall |=> token_valid)
        else $error("token beat dropped while stalled");

    // A stalled token beat keeps its payload.
    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_stall |=> $stable(token_data))
        else $error("token payload changed while stalled");

    // Every token covers at least one byte and has a defined kind.
    a_kind_len: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid |-> (token_data.lexeme_length != '0) &&
                        (token_data.token_kind <= K_UNKNOWN))
        else $error("token with empty lexeme or undefined kind");

    // Two-character operators are two bytes long.
    a_pair_len: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && (token_data.token_kind >= K_INC) && (token_data.token_kind <= K_NE)
        |-> token_data.lexeme_length == LEN_BITS'(2))
        else $error("operator pair with wrong length");

    // Single symbols and unknown bytes are one byte long.
    a_single_len: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && (token_data.token_kind >= K_LPAREN)
        |-> token_data.lexeme_length == LEN_BITS'(1))
        else $error("single symbol with wrong length");

endmodule

bind c_like_token_scanner_top tks_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token_data  (token_data)
);

`default_nettype wire

[dv/tb_c_like_token_scanner_top.sv]
// Self-checking testbench for the token scanner: directed and random source text.
module tb_c_like_token_scanner_top;
    import tks_pkg::*;

    typedef logic [7:0] char_q_t[$];

    // One source byte waiting to be sent, with the idle cycles before it.
    typedef struct {
        in_item_t beat;
        int       gap;
        bit       drain;
    } text_byte_t;

    localparam logic [7:0] NEWLINE   = 8'h0A;
    localparam logic [7:0] SPACE     = 8'h20;
    localparam int         LONG_WORD = 12;

    logic      clk         = 1'b0;
    logic      rst_n       = 1'b0;
    logic      byte_valid  = 1'b0;
    logic      byte_stall;
    in_item_t  byte_data   = '0;
    logic      token_valid;
    logic      token_stall = 1'b0;
    out_item_t token_data;

    // Scanner state as the testbench tracks it.
    scan_mode_t          sc_mode;
    logic [POS_BITS-1:0] sc_pos;
    logic [POS_BITS-1:0] sc_start;
    logic [LEN_BITS-1:0] sc_len;
    logic [KW_BITS-1:0]  sc_word;
    logic [7:0]          sc_held;

    string symbol_set = "()[]{}.+-*/%<>=;,!&|";
    string twin_set   = "++--<=>===&&||!=";

    out_item_t  step_tokens[$];
    out_item_t  expected_tokens[$];
    text_byte_t pending_bytes[$];

    int fail_count  = 0;
    int tokens_seen = 0;
    int rx_style    = 0;
    int hold_left   = 0;
    int stall_left  = 0;

    c_like_token_scanner_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .byte_data   (byte_data),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_data  (token_data)
    );

    // Clock with a period of 10.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Character classes.
    function automatic bit is_blank(logic [7:0] c);
        return c == SPACE || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_opchar(logic [7:0] c);
        return c == "+" || c == "-" || c == "<" || c == ">" || c == "=" ||
               c == "&" || c == "|" || c == "!" || c == "/";
    endfunction

    // Kind of a lone symbol byte, unknown when it is not listed.
    function automatic kind_t symbol_kind(logic [7:0] c);
        int i;
        for (i = 0; i < symbol_set.len(); i++)
            if (symbol_set[i] == c)
                return kind_t'(K_LPAREN + i);
        return K_UNKNOWN;
    endfunction

    // Kind of a two-byte operator, unknown when the bytes form no pair.
    function automatic kind_t twin_kind(logic [7:0] a, logic [7:0] b);
        int i;
        for (i = 0; i < 8; i++)
            if (twin_set[2*i] == a && twin_set[2*i+1] == b)
                return kind_t'(K_INC + i);
        return K_UNKNOWN;
    endfunction

    // Keyword lookup on the pending identifier.
    function automatic kind_t word_kind();
        string names[10] = '{"do", "if", "else", "while", "break", "main",
                             "float", "int", "char", "void"};
        kind_t kinds[10] = '{K_DO, K_IF, K_ELSE, K_WHILE, K_BREAK, K_MAIN,
                             K_BASIC, K_BASIC, K_BASIC, K_BASIC};
        int    i;
        int    j;
        bit    hit;
        if (sc_len > KW_CHARS)
            return K_ID;
        for (i = 0; i < 10; i++)
        begin
            if (names[i].len() == sc_len)
            begin
                hit = 1'b1;
                for (j = 0; j < names[i].len(); j++)
                    if (sc_word[8*j +: 8] != names[i][j])
                        hit = 1'b0;
                if (hit)
                    return kinds[i];
            end
        end
        return K_ID;
    endfunction

    function automatic void clear_scanner();
        sc_mode  = MODE_IDLE;
        sc_pos   = '0;
        sc_start = '0;
        sc_len   = '0;
        sc_word  = '0;
        sc_held  = '0;
    endfunction

    function automatic void add_token(kind_t kind, logic [POS_BITS-1:0] start,
                                      logic [LEN_BITS-1:0] len);
        out_item_t t;
        t               = '0;
        t.token_kind    = kind;
        t.lexeme_start  = START_BITS'(start);
        t.lexeme_length = len;
        step_tokens.insert(step_tokens.size(), t);
    endfunction

    function automatic void grow_token();
        if (sc_len != LEN_MAX)
            sc_len = sc_len + 1'b1;
    endfunction

    // Emit whatever token is open and go idle.
    function automatic void close_token();
        case (sc_mode)
            MODE_IDENT: add_token(word_kind(), sc_start, sc_len);
            MODE_INT:   add_token(K_NUM, sc_start, sc_len);
            MODE_REAL:  add_token(K_REAL, sc_start, sc_len);
            MODE_HELD:  add_token(symbol_kind(sc_held), sc_start, LEN_BITS'(1));
            default: ;
        endcase
        sc_mode = MODE_IDLE;
    endfunction

    // Scan a byte with nothing pending.
    function automatic void open_token(logic [7:0] c, logic [POS_BITS-1:0] p);
        sc_mode = MODE_IDLE;
        if (is_blank(c))
            return;
        sc_start = p;
        sc_len   = LEN_BITS'(1);
        if (is_letter(c))
        begin
            sc_mode = MODE_IDENT;
            sc_word = KW_BITS'(c);
        end
        else if (is_num(c))
            sc_mode = MODE_INT;
        else if (is_opchar(c))
        begin
            sc_mode = MODE_HELD;
            sc_held = c;
        end
        else
            add_token(symbol_kind(c), p, LEN_BITS'(1));
    endfunction

    // Advance the tracked scanner by one accepted byte and queue its tokens.
    function automatic void predict_tokens(in_item_t b);
        logic [7:0]          c;
        logic [POS_BITS-1:0] p;
        kind_t               pk;
        c = b.char_in;
        p = sc_pos;
        step_tokens.delete();
        case (sc_mode)
            MODE_IDENT:
                if (is_letter(c) || is_num(c))
                begin
                    if (sc_len < KW_CHARS)
                        sc_word[8*sc_len +: 8] = c;
                    grow_token();
                end
                else
                begin
                    close_token();
                    open_token(c, p);
                end
            MODE_INT:
                if (is_num(c))
                    grow_token();
                else if (c == ".")
                begin
                    sc_mode = MODE_REAL;
                    grow_token();
                end
                else
                begin
                    close_token();
                    open_token(c, p);
                end
            MODE_REAL:
                if (is_num(c))
                    grow_token();
                else
                begin
                    close_token();
                    open_token(c, p);
                end
            MODE_HELD:
            begin
                pk = twin_kind(sc_held, c);
                if (sc_held == "/" && c == "/")
                    sc_mode = MODE_COMMENT;
                else if (pk != K_UNKNOWN)
                begin
                    add_token(pk, sc_start, LEN_BITS'(2));
                    sc_mode = MODE_IDLE;
                end
                else
                begin
                    close_token();
                    open_token(c, p);
                end
            end
            MODE_COMMENT:
                if (c == NEWLINE)
                    sc_mode = MODE_IDLE;
            default:
                open_token(c, p);
        endcase
        sc_pos = p + 1'b1;
        // The final byte flushes the open token and starts a new text.
        if (b.text_end)
        begin
            close_token();
            clear_scanner();
        end
        foreach (step_tokens[k])
        begin
            step_tokens[k].run_last   = (k == step_tokens.size() - 1);
            step_tokens[k].stream_end = b.text_end;
            expected_tokens.insert(expected_tokens.size(), step_tokens[k]);
        end
    endfunction

    // Compare one token beat with the oldest expected token.
    function automatic void check_token(out_item_t got);
        out_item_t want;
        if (expected_tokens.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected token: kind %0d start %0d length %0d",
                         got.token_kind, got.lexeme_start, got.lexeme_length);
            return;
        end
        want = expected_tokens.pop_front();
        if (got.token_kind !== want.token_kind || got.lexeme_start !== want.lexeme_start ||
            got.lexeme_length !== want.lexeme_length || got.run_last !== want.run_last ||
            got.stream_end !== want.stream_end)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("token mismatch: expected %0d/%0d/%0d/%0b/%0b got %0d/%0d/%0d/%0b/%0b",
                         want.token_kind, want.lexeme_start, want.lexeme_length,
                         want.run_last, want.stream_end, got.token_kind, got.lexeme_start,
                         got.lexeme_length, got.run_last, got.stream_end);
        end
    endfunction

    // Idle time drawn for one beat by style: none, uniform random, or mostly none.
    function automatic int draw_wait(int style);
        case (style)
            0:       return 0;
            1:       return $urandom_range(0, 17);
            default: return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 17) : 0;
        endcase
    endfunction

    // Add one byte at the end of a text.
    function automatic void put_char(ref char_q_t q, input logic [7:0] ch);
        q.insert(q.size(), ch);
    endfunction

    function automatic void append_str(ref char_q_t q, input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            put_char(q, s[i]);
    endfunction

    function automatic logic [7:0] random_letter();
        return $urandom_range(0, 1) ? 8'($urandom_range("a", "z")) : 8'($urandom_range("A", "Z"));
    endfunction

    function automatic logic [7:0] random_digit();
        return 8'($urandom_range("0", "9"));
    endfunction

    // Append one well-formed lexeme with random content.
    function automatic void add_lexeme(ref char_q_t q);
        string words[14] = '{"do", "if", "else", "while", "break", "main", "float",
                             "int", "char", "void", "dox", "whiles", "i", "floats"};
        int    i;
        case ($urandom_range(0, 7))
            0: append_str(q, words[$urandom_range(0, 13)]);
            1:
            begin
                put_char(q, random_letter());
                repeat ($urandom_range(0, 7))
                    put_char(q, $urandom_range(0, 3) == 0 ? random_digit() : random_letter());
            end
            2:
                repeat ($urandom_range(1, 6))
                    put_char(q, random_digit());
            3:
            begin
                repeat ($urandom_range(1, 4))
                    put_char(q, random_digit());
                put_char(q, ".");
                repeat ($urandom_range(0, 3))
                    put_char(q, random_digit());
            end
            4:
            begin
                i = $urandom_range(0, 7);
                put_char(q, twin_set[2*i]);
                put_char(q, twin_set[2*i+1]);
            end
            5, 6: put_char(q, symbol_set[$urandom_range(0, 19)]);
            default:
            begin
                append_str(q, "//");
                repeat ($urandom_range(0, 6))
                    put_char(q, 8'($urandom_range(32, 126)));
                if ($urandom_range(0, 3) != 0)
                    put_char(q, NEWLINE);
            end
        endcase
    endfunction

    // Queue one text as byte beats, the final byte flagged.
    function automatic void queue_text(char_q_t chars, int style, bit drain);
        text_byte_t item;
        int         i;
        for (i = 0; i < chars.size(); i++)
        begin
            item.beat.char_in  = chars[i];
            item.beat.text_end = (i == chars.size() - 1);
            item.gap           = draw_wait(style);
            item.drain         = drain && (i == 0);
            pending_bytes.insert(pending_bytes.size(), item);
        end
    endfunction

    // Byte driver: predicts on every accepted beat, then presents the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            byte_data  <= '0;
            hold_left  <= 0;
        end
        else if (!(byte_valid && byte_stall))
        begin
            if (byte_valid)
                predict_tokens(byte_data);
            if (hold_left != 0)
            begin
                byte_valid <= 1'b0;
                hold_left  <= hold_left - 1;
            end
            else if (pending_bytes.size() == 0 ||
                     (pending_bytes[0].drain && expected_tokens.size() != 0))
                byte_valid <= 1'b0;
            else if (pending_bytes[0].gap != 0)
            begin
                byte_valid           <= 1'b0;
                hold_left            <= pending_bytes[0].gap - 1;
                pending_bytes[0].gap  = 0;
            end
            else
            begin
                byte_valid <= 1'b1;
                byte_data  <= pending_bytes[0].beat;
                void'(pending_bytes.pop_front());
            end
        end
    end

    // Token monitor: checks every accepted beat and stalls for a drawn time after it.
    always @(posedge clk or negedge rst_n)
    begin : token_side
        int wait_n;
        if (!rst_n)
        begin
            token_stall <= 1'b0;
            stall_left  <= 0;
        end
        else if (stall_left != 0)
            stall_left <= stall_left - 1;
        else if (token_valid && !token_stall)
        begin
            check_token(token_data);
            tokens_seen++;
            if (tokens_seen % 40 == 0)
                rx_style = $urandom_range(0, 2);
            wait_n = draw_wait(rx_style);
            token_stall <= (wait_n != 0);
            stall_left  <= (wait_n != 0) ? wait_n - 1 : 0;
        end
        else
            token_stall <= 1'b0;
    end

    // Stimulus and end of run.
    initial
    begin
        string   directed[7];
        char_q_t text;
        int      n;
        int      k;
        directed = '{"12.", "3.14.x/", "a//b\nc", "//", "do whilex break\t ",
                     "if(a<=b)!=c", "+"};
        clear_scanner();

        // Directed texts: unknown bytes, reals, comments, held operators.
        text = '{8'hFF, 8'h00, 8'h80, 8'h7F};
        queue_text(text, 0, 1'b0);
        foreach (directed[i])
        begin
            text.delete();
            append_str(text, directed[i]);
            queue_text(text, i % 3, i == 3);
        end

        // One identifier longer than any keyword.
        text.delete();
        repeat (LONG_WORD)
            put_char(text, "q");
        append_str(text, " z");
        queue_text(text, 0, 1'b1);

        // Random texts of lexemes, blanks and stray bytes.
        n = 0;
        while (n < 1100)
        begin
            text.delete();
            repeat ($urandom_range(1, 12))
            begin
                if ($urandom_range(0, 6) == 0)
                    put_char(text, 8'($urandom_range(0, 255)));
                else
                    add_lexeme(text);
                if ($urandom_range(0, 1))
                begin
                    k = $urandom_range(8, 13);
                    put_char(text, k == 8 ? SPACE : 8'(k));
                end
            end
            n += text.size();
            queue_text(text, $urandom_range(0, 2), $urandom_range(0, 9) == 0);
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_bytes.size() == 0 && !byte_valid);
        wait (expected_tokens.size() == 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && expected_tokens.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
